/* sv/rh61_pkg.sv */
// Shared types and constants for the mod 2^61-1 rolling hash block.
// Used by the modular multiplier and the top level; depends on nothing.
package rh61_pkg;

  localparam int HASH_W = 61;
  localparam logic [HASH_W-1:0] MOD61 = {HASH_W{1'b1}};

  // Operands are split into a 31-bit low half and a 30-bit high half.
  localparam int LO_W   = 31;
  localparam int HI_W   = HASH_W - LO_W;
  localparam int PROD_W = 2 * LO_W;
  localparam int ACC_W  = 64;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_WHOLE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    logic [BYTE_W-1:0] addend;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] result;
  } mm_rsp_t;

endpackage

/* sv/rh61_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module rh61_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 1025,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rh61_mulmod.sv */
// Iterative multiplier: result = (a * b + addend) mod 2^61-1.
// One 31x31 multiplier is reused over four partial products; uses rh61_pkg.
module rh61_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  rh61_pkg::mm_req_t req,
  output rh61_pkg::mm_rsp_t rsp
);
  import rh61_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL0 = 3'd1;
  localparam logic [2:0] PH_ACC0 = 3'd2;
  localparam logic [2:0] PH_ACC3 = 3'd5;
  localparam logic [2:0] PH_FOLD = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [HASH_W-1:0] a_r, b_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0] pp_r, pp_nxt;
  logic [HASH_W-1:0] res_r, res_nxt;
  logic              done_r;
  logic [1:0]        mul_step, acc_step;
  logic [LO_W-1:0]   op_a, op_b;
  logic [ACC_W-1:0]  term;
  logic [HASH_W:0]   fold_sum, fold_red;

  assign mul_step = 2'(phase_r - PH_MUL0);
  assign acc_step = 2'(phase_r - PH_ACC0);

  // Step order: lo*lo, lo*hi, hi*lo, hi*hi.
  assign op_a = mul_step[1] ? {1'b0, a_r[HASH_W-1:LO_W]} : a_r[LO_W-1:0];
  assign op_b = mul_step[0] ? {1'b0, b_r[HASH_W-1:LO_W]} : b_r[LO_W-1:0];
  assign pp_nxt = {{LO_W{1'b0}}, op_a} * {{LO_W{1'b0}}, op_b};

  // Cross products carry weight 2^31; x * 2^31 is folded as (x >> 30) plus
  // the low 30 bits moved up by 31, since 2^61 is congruent to 1. The high
  // product carries weight 2^62, which is congruent to 2.
  always_comb begin
    if (acc_step == 2'd0) begin
      term = ACC_W'(pp_r);
    end else if (acc_step == 2'd3) begin
      term = ACC_W'({pp_r, 1'b0});
    end else begin
      term = ACC_W'(pp_r[PROD_W-1:HI_W]) + ACC_W'({pp_r[HI_W-1:0], {LO_W{1'b0}}});
    end
  end

  assign fold_sum = (HASH_W+1)'(acc_r[ACC_W-1:HASH_W]) + {1'b0, acc_r[HASH_W-1:0]};
  assign fold_red = (fold_sum >= {1'b0, MOD61}) ? fold_sum - {1'b0, MOD61} : fold_sum;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    if (phase_r == PH_IDLE) begin
      if (req.start) begin
        phase_nxt = PH_MUL0;
        acc_nxt   = ACC_W'(req.addend);
      end
    end else if (phase_r == PH_FOLD) begin
      phase_nxt = PH_IDLE;
      res_nxt   = fold_red[HASH_W-1:0];
    end else begin
      phase_nxt = phase_r + 3'd1;
    end
    if (phase_r inside {[PH_ACC0:PH_ACC3]}) begin
      acc_nxt = acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == PH_FOLD);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pp_r  <= pp_nxt;
    res_r <= res_nxt;
    if (phase_r == PH_IDLE && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

/* sv/mersenne61_rolling_hash.sv */
// Top level of the mod 2^61-1 rolling hash: sequencer, registers, stores.
// Depends on rh61_pkg, rh61_ram and rh61_mulmod.
//
//  Port group   Handshake              Moves
//  cfg (APB)    psel/penable/pwrite    base register at byte address 0
//  in_*         in_valid / in_ready    command, char_value, left, right, whole
//  out_*        out_valid / out_ready  hash_value, status, length
//
// An append makes two passes through the shared multiplier (each pass: four
// partial products, drain, fold, done). A range query makes two prefix reads
// and one multiplier pass. Clear, whole-string queries, full appends, bad
// ranges and the unused command code go straight to the result state.
// in_ready is high only while the sequencer idles; a waiting result does not
// block the next word. Reset is synchronous; the stores need no clearing pass.
module mersenne61_rolling_hash #(
  parameter int MAX_LEN = 1024,
  localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [rh61_pkg::BYTE_W-1:0] in_char_value,
  input  logic [LEN_W-1:0]            in_left,
  input  logic [LEN_W-1:0]            in_right,
  input  logic                        in_whole,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rh61_pkg::HASH_W-1:0] out_hash_value,
  output logic [1:0]                  out_status,
  output logic [LEN_W-1:0]            out_length
);
  import rh61_pkg::*;

  localparam int BASE_W = 24;
  localparam logic REG_BASE = 1'b0;
  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
  localparam logic [HASH_W-1:0] ONE61 = HASH_W'(1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_QRD   = 7'b0000010,
    S_QRR   = 7'b0000100,
    S_QMUL  = 7'b0001000,
    S_AHASH = 7'b0010000,
    S_APOW  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [HASH_W-1:0] last_hash_r, last_hash_nxt;
  logic [HASH_W-1:0] last_pow_r, last_pow_nxt;
  logic [LEN_W-1:0]  qr_r, qr_nxt;
  logic              l_zero_r, l_zero_nxt;
  logic              d_zero_r, d_zero_nxt;
  logic              r_zero_r, r_zero_nxt;
  logic [HASH_W-1:0] pr_r, pr_nxt;
  logic [HASH_W-1:0] res_hash_r, res_hash_nxt;
  status_t           res_sts_r, res_sts_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;
  logic [1:0]        out_sts_r, out_sts_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  logic              accept, cfg_wr, out_free;
  logic [LEN_W-1:0]  n_inc;
  logic [LEN_W-1:0]  ph_raddr, pw_raddr, wr_addr;
  logic [HASH_W-1:0] ph_rdata, pw_rdata;
  logic              ph_we, pw_we;
  logic [HASH_W:0]   sub_plain, sub_wrap;
  logic [HASH_W-1:0] base_ext;

  assign accept   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_ready;
  assign n_inc    = n_r + LEN_W'(1);
  assign base_ext = HASH_W'(base_r);

  // Configuration port.
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_BASE) ? 32'(base_r) : 32'd0;
  assign base_nxt = (cfg_wr && paddr[2] == REG_BASE) ? pwdata[BASE_W-1:0] : base_r;

  // Prefix store is read at left on acceptance, then at right.
  assign ph_raddr = (state_r == S_QRD) ? qr_r : in_left;
  assign pw_raddr = in_right - in_left;
  assign wr_addr  = n_inc;
  assign ph_we    = (state_r == S_AHASH) && mm_rsp.done;
  assign pw_we    = (state_r == S_APOW) && mm_rsp.done;

  // h[r] - m mod P, both below P.
  assign sub_plain = {1'b0, pr_r} - {1'b0, mm_rsp.result};
  assign sub_wrap  = {1'b0, pr_r} + {1'b0, MOD61} - {1'b0, mm_rsp.result};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    last_hash_nxt = last_hash_r;
    last_pow_nxt  = last_pow_r;
    qr_nxt        = qr_r;
    l_zero_nxt    = l_zero_r;
    d_zero_nxt    = d_zero_r;
    r_zero_nxt    = r_zero_r;
    pr_nxt        = pr_r;
    res_hash_nxt  = res_hash_r;
    res_sts_nxt   = res_sts_r;
    res_len_nxt   = res_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;
    out_sts_nxt   = out_sts_r;
    out_len_nxt   = out_len_r;
    mm_req.start  = 1'b0;
    mm_req.a      = last_hash_r;
    mm_req.b      = base_ext;
    mm_req.addend = in_char_value;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_sts_nxt  = STS_OK;
          res_len_nxt  = n_r;
          res_hash_nxt = last_hash_r;
          state_nxt    = S_DONE;
          case (in_command)
            CMD_APPEND: begin
              if (n_r >= LEN_MAX) begin
                res_sts_nxt = STS_FULL;
              end else begin
                mm_req.start = 1'b1;
                state_nxt    = S_AHASH;
              end
            end
            CMD_CLEAR: begin
              n_nxt         = '0;
              last_hash_nxt = '0;
              last_pow_nxt  = ONE61;
              res_hash_nxt  = '0;
              res_len_nxt   = '0;
            end
            CMD_QUERY: begin
              if (in_whole) begin
                res_hash_nxt = last_hash_r;
              end else if (in_left > in_right || in_right > n_r) begin
                res_sts_nxt  = STS_RANGE;
                res_hash_nxt = '0;
              end else begin
                qr_nxt     = in_right;
                l_zero_nxt = (in_left == '0);
                d_zero_nxt = (in_left == in_right);
                r_zero_nxt = (in_right == '0);
                state_nxt  = S_QRD;
              end
            end
            default: begin
              // The unused code reads back the whole-string hash.
              res_hash_nxt = last_hash_r;
            end
          endcase
        end
      end
      S_QRD: begin
        // Entry 0 of each store is never written; its fixed value is used here.
        mm_req.start  = 1'b1;
        mm_req.a      = l_zero_r ? '0 : ph_rdata;
        mm_req.b      = d_zero_r ? ONE61 : pw_rdata;
        mm_req.addend = '0;
        state_nxt     = S_QRR;
      end
      S_QRR: begin
        pr_nxt    = r_zero_r ? '0 : ph_rdata;
        state_nxt = S_QMUL;
      end
      S_QMUL: begin
        if (mm_rsp.done) begin
          res_hash_nxt = sub_plain[HASH_W] ? sub_wrap[HASH_W-1:0] : sub_plain[HASH_W-1:0];
          state_nxt    = S_DONE;
        end
      end
      S_AHASH: begin
        if (mm_rsp.done) begin
          last_hash_nxt = mm_rsp.result;
          mm_req.start  = 1'b1;
          mm_req.a      = last_pow_r;
          mm_req.addend = '0;
          state_nxt     = S_APOW;
        end
      end
      S_APOW: begin
        if (mm_rsp.done) begin
          last_pow_nxt = mm_rsp.result;
          n_nxt        = n_inc;
          res_hash_nxt = last_hash_r;
          res_sts_nxt  = STS_OK;
          res_len_nxt  = n_inc;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res_hash_r;
          out_sts_nxt   = res_sts_r;
          out_len_nxt   = res_len_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RST;
      n_r         <= '0;
      last_hash_r <= '0;
      last_pow_r  <= ONE61;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      n_r         <= n_nxt;
      last_hash_r <= last_hash_nxt;
      last_pow_r  <= last_pow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qr_r       <= qr_nxt;
    l_zero_r   <= l_zero_nxt;
    d_zero_r   <= d_zero_nxt;
    r_zero_r   <= r_zero_nxt;
    pr_r       <= pr_nxt;
    res_hash_r <= res_hash_nxt;
    res_sts_r  <= res_sts_nxt;
    res_len_r  <= res_len_nxt;
    out_hash_r <= out_hash_nxt;
    out_sts_r  <= out_sts_nxt;
    out_len_r  <= out_len_nxt;
  end

  rh61_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  rh61_ram #(
    .WIDTH (HASH_W),
    .DEPTH (MAX_LEN + 1)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ph_we),
    .waddr (wr_addr),
    .wdata (mm_rsp.result),
    .raddr (ph_raddr),
    .rdata (ph_rdata)
  );

  rh61_ram #(
    .WIDTH (HASH_W),
    .DEPTH (MAX_LEN + 1)
  ) u_power_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (wr_addr),
    .wdata (mm_rsp.result),
    .raddr (pw_raddr),
    .rdata (pw_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_status     = out_sts_r;
  assign out_length     = out_len_r;

endmodule

/* test/mersenne61_rolling_hash_tb.sv */
// Self-checking testbench for the mod 2^61-1 rolling hash block.
// Holds a scoreboard class that predicts every result word; depends on rh61_pkg
// and on the mersenne61_rolling_hash top level.
`timescale 1ns / 100ps

module mersenne61_rolling_hash_tb;
  import rh61_pkg::*;

  class hash_scoreboard;
    localparam int STR_MAX = 1024;
    localparam bit [63:0] P61 = (64'd1 << 61) - 64'd1;

    typedef struct {
      bit [HASH_W-1:0] hash;
      status_t         status;
      bit [10:0]       length;
    } hash_word_t;

    bit [HASH_W-1:0] prefix_hash [STR_MAX+1];
    bit [HASH_W-1:0] base_pow [STR_MAX+1];
    int unsigned     str_len;
    bit [23:0]       base_mult;
    hash_word_t      expected_words [$];
    int              mismatches;

    function new();
      prefix_hash[0] = '0;
      base_pow[0]    = 61'd1;
      str_len        = 0;
      base_mult      = 24'd2;
      mismatches     = 0;
    endfunction

    // Exact (a * b + c) mod P on a wide accumulator.
    static function bit [HASH_W-1:0] mul_add_mod(bit [HASH_W-1:0] a, bit [HASH_W-1:0] b,
                                                 bit [7:0] c);
      bit [127:0] acc;
      acc = 128'(a) * 128'(b) + 128'(c);
      return HASH_W'(acc % 128'(P61));
    endfunction

    function void set_base(bit [23:0] value);
      base_mult = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_input(cmd_t cmd, bit [7:0] ch, bit [10:0] l, bit [10:0] r, bit w);
      hash_word_t      res;
      bit [HASH_W-1:0] sub;
      bit [63:0]       diff;
      res.hash   = '0;
      res.status = STS_OK;
      case (cmd)
        CMD_APPEND: begin
          if (str_len >= STR_MAX) begin
            res.status = STS_FULL;
            res.hash   = prefix_hash[str_len];
          end else begin
            prefix_hash[str_len+1] = mul_add_mod(prefix_hash[str_len], HASH_W'(base_mult), ch);
            base_pow[str_len+1]    = mul_add_mod(base_pow[str_len], HASH_W'(base_mult), 8'd0);
            str_len++;
            res.hash = prefix_hash[str_len];
          end
        end
        CMD_CLEAR: begin
          str_len = 0;
        end
        CMD_QUERY: begin
          if (w) begin
            res.hash = prefix_hash[str_len];
          end else if (l > r || r > str_len) begin
            res.status = STS_RANGE;
          end else begin
            sub  = mul_add_mod(prefix_hash[l], base_pow[r-l], 8'd0);
            diff = 64'(prefix_hash[r]) + (P61 - 64'(sub));
            if (diff >= P61) begin
              diff = diff - P61;
            end
            res.hash = HASH_W'(diff);
          end
        end
        default: begin
          // The spare command code reads back the whole string and changes nothing.
          res.hash = prefix_hash[str_len];
        end
      endcase
      res.length = 11'(str_len);
      expected_words.push_back(res);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [HASH_W-1:0] hash, logic [1:0] status, logic [10:0] length);
      hash_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word with nothing expected (hash %0h)", hash));
      end else begin
        want = expected_words.pop_front();
        if (hash !== want.hash) begin
          report($sformatf("hash_value got %0h want %0h", hash, want.hash));
        end
        if (status !== want.status) begin
          report($sformatf("status got %0d want %0d", status, want.status));
        end
        if (length !== want.length) begin
          report($sformatf("length got %0d want %0d", length, want.length));
        end
      end
    endtask
  endclass

  localparam int MAX_LEN        = 1024;
  localparam int LEN_W          = 11;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 24;
  localparam bit [2:0] BASE_ADDR  = 3'd0;
  localparam bit [2:0] SPARE_ADDR = 3'd4;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_command;
  logic [BYTE_W-1:0]    in_char_value;
  logic [LEN_W-1:0]     in_left;
  logic [LEN_W-1:0]     in_right;
  logic                 in_whole;
  logic                 out_valid;
  logic                 out_ready;
  logic [HASH_W-1:0]    out_hash_value;
  logic [1:0]           out_status;
  logic [LEN_W-1:0]     out_length;

  bit tx_gaps;
  bit rx_stalls;
  int stall_count;

  hash_scoreboard hash_sb = new();

  mersenne61_rolling_hash #(.MAX_LEN(MAX_LEN)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_char_value (in_char_value),
    .in_left       (in_left),
    .in_right      (in_right),
    .in_whole      (in_whole),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hash_value(out_hash_value),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops for random bursts while stalls are enabled.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hash_sb.check_result(out_hash_value, out_status, out_length);
    end
  end

  initial begin
    stall_count = 0;
    while (stall_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("** mersenne61_rolling_hash: FAILED **");
    $finish;
  end

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(cmd_t cmd, bit [7:0] ch, bit [10:0] l, bit [10:0] r, bit w);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_value <= ch;
    in_left       <= l;
    in_right      <= r;
    in_whole      <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    hash_sb.note_input(cmd, ch, l, r, w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hash_sb.pending() != 0) @(posedge clk);
  endtask

  // Writes a register, then reads the base back.
  task automatic write_reg(bit [2:0] addr, bit [31:0] data);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == BASE_ADDR) begin
      hash_sb.set_base(data[23:0]);
    end
    @(posedge clk);
    psel  <= 1'b1;
    paddr <= BASE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {8'd0, hash_sb.base_mult}) begin
      hash_sb.report($sformatf("base read back %0h want %0h", prdata, hash_sb.base_mult));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned pick;
    int unsigned n;
    bit [10:0]   l;
    bit [10:0]   r;
    pick = $urandom_range(0, 99);
    n    = hash_sb.str_len;
    if (pick < 45) begin
      send_word(CMD_APPEND, 8'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
    end else if (pick < 75) begin
      r = 11'($urandom_range(0, n));
      l = 11'($urandom_range(0, r));
      send_word(CMD_QUERY, 8'($urandom), l, r, 1'b0);
    end else if (pick < 83) begin
      send_word(CMD_QUERY, 8'($urandom), 11'($urandom), 11'($urandom), 1'b1);
    end else if (pick < 93) begin
      // Mostly broken ranges: just past the end, reversed, or anything at all.
      if ($urandom_range(0, 2) == 0) begin
        r = 11'(n + 1);
        l = 11'($urandom_range(0, n));
      end else if ($urandom_range(0, 1) == 0) begin
        l = 11'($urandom_range(1, n + 1));
        r = 11'($urandom_range(0, l - 1));
      end else begin
        l = 11'($urandom);
        r = 11'($urandom);
      end
      send_word(CMD_QUERY, 8'($urandom), l, r, 1'b0);
    end else if (pick < 97) begin
      send_word(CMD_WHOLE, 8'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
    end else begin
      send_word(CMD_CLEAR, 8'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(bit [31:0] base_word, int count);
    write_reg(BASE_ADDR, base_word);
    repeat (count) random_word();
  endtask

  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_command    <= CMD_APPEND;
    in_char_value <= '0;
    in_left       <= '0;
    in_right      <= '0;
    in_whole      <= 1'b0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on the reset base: empty string, byte extremes, range edges.
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd0, 1'b1);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd0, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd1, 1'b0);
    send_word(CMD_WHOLE, 8'hFF, 11'd2047, 11'd2047, 1'b1);
    send_word(CMD_APPEND, 8'h00, 11'd0, 11'd0, 1'b0);
    send_word(CMD_APPEND, 8'hFF, 11'd2047, 11'd2047, 1'b1);
    send_word(CMD_APPEND, 8'h80, 11'd0, 11'd0, 1'b0);
    send_word(CMD_APPEND, 8'h7F, 11'd0, 11'd0, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd4, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd1, 11'd3, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd4, 11'd4, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd3, 11'd2, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd5, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd2047, 11'd2047, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd2047, 11'd1, 1'b1);
    send_word(CMD_WHOLE, 8'd0, 11'd0, 11'd0, 1'b0);
    send_word(CMD_CLEAR, 8'hFF, 11'd2047, 11'd2047, 1'b1);
    send_word(CMD_APPEND, 8'h55, 11'd0, 11'd0, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd1, 1'b0);
    send_word(CMD_CLEAR, 8'd0, 11'd0, 11'd0, 1'b0);
    send_word(CMD_QUERY, 8'd0, 11'd0, 11'd0, 1'b1);

    // Base extremes; the upper data bits of the register write are ignored.
    random_phase({8'($urandom), 24'd0}, 130);
    random_phase(32'd1, 130);
    random_phase(32'hFFFF_FFFF, 130);
    random_phase(32'd10000001, 130);
    random_phase({8'($urandom), 24'($urandom)}, 130);

    // A write to an unmapped address must leave the base alone.
    write_reg(SPARE_ADDR, $urandom);
    repeat (60) random_word();

    random_phase({8'd0, 24'($urandom_range(2, 10000001))}, 60);

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    random_phase(32'd2, 110);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (hash_sb.mismatches == 0) begin
      $display("** mersenne61_rolling_hash: PASSED **");
    end else begin
      $display("** mersenne61_rolling_hash: FAILED **");
    end
    $finish;
  end
endmodule
